// ----- rtl/brtc_pkg.sv -----
// Shared types and constants for the binomial tree row collapse block.
// Used by brtc_cell and binomial_tree_row_collapse_top; no dependencies.

package brtc_pkg;

	localparam int VALUE_W    = 48;
	localparam int FRAC_W     = 32;
	localparam int HI_W       = VALUE_W - FRAC_W;
	localparam int WIDE_W     = VALUE_W + FRAC_W;
	localparam int PROB_W     = 33;
	localparam int CHUNK_W    = 7;
	localparam int START_W    = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 33;
	localparam int CELL_LAT   = 5;

	localparam logic [PROB_W-1:0] ONE_Q32  = {1'b1, {FRAC_W{1'b0}}};
	localparam logic [PROB_W-1:0] HALF_Q32 = {2'b01, {(FRAC_W - 1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UP_PROB    = 2'd0,
		REG_DISCOUNT   = 2'd1,
		REG_CHUNK_ROWS = 2'd2,
		REG_ROW_START  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic valid;
		logic emit;
		logic last;
	} tok_ctl_t;

endpackage

// ----- rtl/brtc_cell.sv -----
// One wavefront cell: a five-stage discounted mix unit and the stored node value.
// Depends on brtc_pkg.

module brtc_cell
	import brtc_pkg::*;
#(
	parameter int CW = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [PROB_W-1:0]  q,
	input  logic [PROB_W-1:0]  qc,
	input  logic [PROB_W-1:0]  dsc,
	input  tok_ctl_t           in_ctl,
	input  logic [CW-1:0]      in_cnt,
	input  logic [VALUE_W-1:0] in_new,
	input  logic [VALUE_W-1:0] in_old,
	input  logic [VALUE_W-1:0] in_result,
	output tok_ctl_t           out_ctl,
	output logic [CW-1:0]      out_cnt,
	output logic [VALUE_W-1:0] out_new,
	output logic [VALUE_W-1:0] out_old,
	output logic [VALUE_W-1:0] out_result
);

	tok_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [CW-1:0] cnt_s1, cnt_s2, cnt_s3, cnt_s4, cnt_s5;
	logic [VALUE_W-1:0] res_s1, res_s2, res_s3, res_s4, res_s5;

	logic [2*FRAC_W-1:0]     pal_s1, pbl_s1;
	logic [HI_W+FRAC_W-1:0]  pah_s1, pbh_s1;
	logic [VALUE_W-1:0]      af_s1, bf_s1;
	logic [WIDE_W-1:0]       qa_s2, qb_s2;
	logic [VALUE_W-1:0]      mix_s3;
	logic [2*FRAC_W-1:0]     ml_s4;
	logic [HI_W+FRAC_W-1:0]  mh_s4;
	logic [VALUE_W-1:0]      mf_s4;
	logic [VALUE_W-1:0]      new_s5, old_s5;
	logic [VALUE_W-1:0]      cell_q;

	logic [WIDE_W-1:0]  mix_sum;
	logic [WIDE_W-1:0]  prod;
	logic [VALUE_W-1:0] r;
	logic               upd;
	logic [VALUE_W-1:0] new_val;

	always_comb begin
		mix_sum = qa_s2 + qb_s2;
		prod    = {mh_s4, {FRAC_W{1'b0}}} + WIDE_W'(ml_s4) + {mf_s4, {FRAC_W{1'b0}}};
		r       = prod[WIDE_W-1:FRAC_W];
		upd     = (cnt_s4 != '0);
		new_val = upd ? r : cell_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s1 <= in_ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cnt_s1 <= in_cnt;
			res_s1 <= in_result;
			pal_s1 <= (2*FRAC_W)'(in_new[FRAC_W-1:0]) * (2*FRAC_W)'(q[FRAC_W-1:0]);
			pah_s1 <= (HI_W+FRAC_W)'(in_new[VALUE_W-1:FRAC_W])
				* (HI_W+FRAC_W)'(q[FRAC_W-1:0]);
			af_s1  <= q[FRAC_W] ? in_new : '0;
			pbl_s1 <= (2*FRAC_W)'(in_old[FRAC_W-1:0]) * (2*FRAC_W)'(qc[FRAC_W-1:0]);
			pbh_s1 <= (HI_W+FRAC_W)'(in_old[VALUE_W-1:FRAC_W])
				* (HI_W+FRAC_W)'(qc[FRAC_W-1:0]);
			bf_s1  <= qc[FRAC_W] ? in_old : '0;

			cnt_s2 <= cnt_s1;
			res_s2 <= res_s1;
			qa_s2  <= {pah_s1, {FRAC_W{1'b0}}} + WIDE_W'(pal_s1) + {af_s1, {FRAC_W{1'b0}}};
			qb_s2  <= {pbh_s1, {FRAC_W{1'b0}}} + WIDE_W'(pbl_s1) + {bf_s1, {FRAC_W{1'b0}}};

			cnt_s3 <= cnt_s2;
			res_s3 <= res_s2;
			mix_s3 <= mix_sum[WIDE_W-1:FRAC_W];

			cnt_s4 <= cnt_s3;
			res_s4 <= res_s3;
			ml_s4  <= (2*FRAC_W)'(mix_s3[FRAC_W-1:0]) * (2*FRAC_W)'(dsc[FRAC_W-1:0]);
			mh_s4  <= (HI_W+FRAC_W)'(mix_s3[VALUE_W-1:FRAC_W])
				* (HI_W+FRAC_W)'(dsc[FRAC_W-1:0]);
			mf_s4  <= dsc[FRAC_W] ? mix_s3 : '0;

			cnt_s5 <= upd ? cnt_s4 - CW'(1) : '0;
			res_s5 <= upd ? r : res_s4;
			new_s5 <= new_val;
			old_s5 <= cell_q;
			if (ctl_s4.valid) begin
				cell_q <= new_val;
			end
		end
	end

	assign out_ctl    = ctl_s5;
	assign out_cnt    = cnt_s5;
	assign out_new    = new_s5;
	assign out_old    = old_s5;
	assign out_result = res_s5;

endmodule

// ----- rtl/binomial_tree_row_collapse_top.sv -----
// Path from request accept to result: the input register, then the chain of MAX_CHUNK cells
// with a five-stage multiply unit each, then the output register.
// Throughput: one node value per cycle when not stalled; a stalled result freezes the whole chain.
// Reset: clears position, valid bits and config to q = 1/2, discount = 1, one row.
// Cell values hold nothing until written. Config requests wait for an empty chain.
// Depends on brtc_pkg and brtc_cell; node requests hold while a config request waits.

module binomial_tree_row_collapse_top
	import brtc_pkg::*;
#(
	parameter int MAX_CHUNK = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_W-1:0]    node_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [VALUE_W-1:0]    result_value,
	output logic                  last_of_row,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW  = $clog2(MAX_CHUNK + 1);
	localparam int LAT = CELL_LAT * MAX_CHUNK + 1;
	localparam int IFW = $clog2(LAT + 1);

	logic [PROB_W-1:0]  up_prob_q, discount_q;
	logic [CHUNK_W-1:0] chunk_rows_q;
	logic [START_W-1:0] row_start_q;
	logic [PROB_W-1:0]  q_q, qc_q, dsc_q;
	logic [START_W-1:0] position_q;
	logic [IFW-1:0]     inflight_q;
	logic [VALUE_W-1:0] cell0_q;

	tok_ctl_t           ctl_s0;
	logic [CW-1:0]      cnt_s0;
	logic [VALUE_W-1:0] new_s0, old_s0, res_s0;

	logic               out_valid_q, last_q;
	logic [VALUE_W-1:0] result_q;

	tok_ctl_t           ctl_c [0:MAX_CHUNK];
	logic [CW-1:0]      cnt_c [0:MAX_CHUNK];
	logic [VALUE_W-1:0] new_c [0:MAX_CHUNK];
	logic [VALUE_W-1:0] old_c [0:MAX_CHUNK];
	logic [VALUE_W-1:0] res_c [0:MAX_CHUNK];

	logic               en, acc, done;
	logic [START_W-1:0] max_ext, rows, depth, maxcol;
	logic               emit, last;
	logic [PROB_W-1:0]  q_sat, dsc_sat;

	always_comb begin
		en      = !out_valid_q || !out_stall;
		acc     = in_valid && en && !cfg_valid;
		done    = en && ctl_c[MAX_CHUNK].valid;
		max_ext = START_W'(MAX_CHUNK);
		rows    = (START_W'(chunk_rows_q) > max_ext) ? max_ext : START_W'(chunk_rows_q);
		depth   = (rows < row_start_q) ? rows : row_start_q;
		maxcol  = (depth < position_q) ? depth : position_q;
		emit    = (position_q >= depth);
		last    = (position_q >= row_start_q);
		q_sat   = (up_prob_q > ONE_Q32) ? ONE_Q32 : up_prob_q;
		dsc_sat = (discount_q > ONE_Q32) ? ONE_Q32 : discount_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_prob_q    <= HALF_Q32;
			discount_q   <= ONE_Q32;
			chunk_rows_q <= CHUNK_W'(1);
			row_start_q  <= START_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_UP_PROB:    up_prob_q    <= cfg_data[PROB_W-1:0];
				REG_DISCOUNT:   discount_q   <= cfg_data[PROB_W-1:0];
				REG_CHUNK_ROWS: chunk_rows_q <= cfg_data[CHUNK_W-1:0];
				REG_ROW_START:  row_start_q  <= cfg_data[START_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		q_q   <= q_sat;
		qc_q  <= ONE_Q32 - q_sat;
		dsc_q <= dsc_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q  <= '0;
			inflight_q  <= '0;
			ctl_s0      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			inflight_q <= inflight_q + IFW'(acc) - IFW'(done);
			if (acc) begin
				position_q <= last ? '0 : position_q + START_W'(1);
			end
			if (en) begin
				ctl_s0.valid <= acc;
				ctl_s0.emit  <= emit;
				ctl_s0.last  <= last;
				out_valid_q  <= ctl_c[MAX_CHUNK].valid && ctl_c[MAX_CHUNK].emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cell0_q <= node_value;
		end
		if (en) begin
			cnt_s0   <= CW'(maxcol);
			new_s0   <= node_value;
			old_s0   <= cell0_q;
			res_s0   <= node_value;
			result_q <= res_c[MAX_CHUNK];
			last_q   <= ctl_c[MAX_CHUNK].last;
		end
	end

	assign ctl_c[0] = ctl_s0;
	assign cnt_c[0] = cnt_s0;
	assign new_c[0] = new_s0;
	assign old_c[0] = old_s0;
	assign res_c[0] = res_s0;

	for (genvar i = 1; i <= MAX_CHUNK; i++) begin : g_cell
		brtc_cell #(
			.CW(CW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.q          (q_q),
			.qc         (qc_q),
			.dsc        (dsc_q),
			.in_ctl     (ctl_c[i-1]),
			.in_cnt     (cnt_c[i-1]),
			.in_new     (new_c[i-1]),
			.in_old     (old_c[i-1]),
			.in_result  (res_c[i-1]),
			.out_ctl    (ctl_c[i]),
			.out_cnt    (cnt_c[i]),
			.out_new    (new_c[i]),
			.out_old    (old_c[i]),
			.out_result (res_c[i])
		);
	end

	assign in_stall     = !en || cfg_valid;
	assign cfg_ready    = (inflight_q == '0);
	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign last_of_row  = last_q;

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for binomial_tree_row_collapse_top: streams tree rows, predicts each
// collapsed node value and row-end flag, and compares the results in order of arrival.
// Depends on brtc_pkg and the block's RTL.

module tb;
	import brtc_pkg::*;

	localparam int MAX_CHUNK    = 64;
	localparam int DRAIN_WAIT   = 5 * MAX_CHUNK + 30;
	localparam int IDLE_LIMIT   = 4000;
	localparam int RANDOM_NODES = 750;

	localparam logic [VALUE_W-1:0]    VALUE_MAX = '1;
	localparam logic [CFG_DATA_W-1:0] DATA_MAX  = '1;
	localparam logic [START_W-1:0]    START_MAX = '1;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic               last;
	} node_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [VALUE_W-1:0]    node_value;
	logic                  out_valid;
	logic                  out_stall;
	logic [VALUE_W-1:0]    result_value;
	logic                  last_of_row;
	logic                  cfg_valid;
	logic                  cfg_ready;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [PROB_W-1:0]  up_prob;
	logic [PROB_W-1:0]  disc;
	logic [CHUNK_W-1:0] chunk;
	logic [START_W-1:0] row_index;
	logic [START_W-1:0] row_pos;
	logic [VALUE_W-1:0] wave [0:MAX_CHUNK];

	node_result_t expected_nodes[$];
	node_result_t want;
	int           mismatches;
	int           idle_cycles;
	int           nodes_sent;
	int           stall_left;
	bit           sink_free;
	bit           burst;

	binomial_tree_row_collapse_top #(
		.MAX_CHUNK(MAX_CHUNK)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.node_value  (node_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_value(result_value),
		.last_of_row (last_of_row),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [VALUE_W-1:0] discounted_mix(input logic [VALUE_W-1:0] up_val,
			input logic [VALUE_W-1:0] down_val);
		logic [PROB_W-1:0] q;
		logic [PROB_W-1:0] d;
		logic [WIDE_W+1:0] mix;
		logic [WIDE_W:0]   scaled;
		q = (up_prob > ONE_Q32) ? ONE_Q32 : up_prob;
		d = (disc > ONE_Q32) ? ONE_Q32 : disc;
		mix = (WIDE_W+2)'(up_val) * (WIDE_W+2)'(q)
			+ (WIDE_W+2)'(down_val) * (WIDE_W+2)'(ONE_Q32 - q);
		scaled = (WIDE_W+1)'(mix[WIDE_W-1:FRAC_W]) * (WIDE_W+1)'(d);
		return scaled[WIDE_W-1:FRAC_W];
	endfunction

	function automatic void collapse_node(input logic [VALUE_W-1:0] v);
		int                 rows;
		int                 depth;
		int                 cols;
		int                 i;
		logic [VALUE_W-1:0] old_left;
		logic [VALUE_W-1:0] fresh;
		logic               last;
		node_result_t       r;
		rows = (int'(chunk) > MAX_CHUNK) ? MAX_CHUNK : int'(chunk);
		depth = (rows < int'(row_index)) ? rows : int'(row_index);
		cols = (depth < int'(row_pos)) ? depth : int'(row_pos);
		old_left = wave[0];
		wave[0] = v;
		for (i = 1; i <= cols; i++) begin
			fresh = discounted_mix(wave[i-1], old_left);
			old_left = wave[i];
			wave[i] = fresh;
		end
		last = (row_pos >= row_index);
		row_pos = last ? '0 : row_pos + START_W'(1);
		if (cols == depth) begin
			r.value = wave[depth];
			r.last = last;
			expected_nodes.push_back(r);
		end
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_node(input logic [VALUE_W-1:0] v);
		int gap;
		in_valid <= 1'b1;
		node_value <= v;
		do @(posedge clk); while (in_stall !== 1'b0);
		collapse_node(v);
		nodes_sent++;
		gap = burst ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_nodes.size() != 0);
	endtask

	task automatic settle();
		hold_until_drained();
		sink_free = 1'b1;
		repeat (DRAIN_WAIT) @(posedge clk);
		sink_free = 1'b0;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_UP_PROB:    up_prob = data;
			REG_DISCOUNT:   disc = data;
			REG_CHUNK_ROWS: chunk = data[CHUNK_W-1:0];
			REG_ROW_START:  row_index = data[START_W-1:0];
			default:        ;
		endcase
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] q, input logic [CFG_DATA_W-1:0] d,
			input logic [CFG_DATA_W-1:0] c, input logic [CFG_DATA_W-1:0] s);
		settle();
		write_reg(REG_UP_PROB, q);
		write_reg(REG_DISCOUNT, d);
		write_reg(REG_CHUNK_ROWS, c);
		write_reg(REG_ROW_START, s);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [VALUE_W-1:0] rand_node();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		case ($urandom_range(0, 3))
			0:       return VALUE_W'(w[23:0]);
			1:       return $urandom_range(0, 1) ? VALUE_MAX : '0;
			default: return w[VALUE_W-1:0];
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_prob();
		logic [CFG_DATA_W-1:0] x;
		x = CFG_DATA_W'({$urandom_range(0, 1), $urandom()});
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return ONE_Q32;
			2:       return x;
			default: return {1'b0, x[FRAC_W-1:0]};
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_discount();
		logic [CFG_DATA_W-1:0] x;
		x = CFG_DATA_W'({$urandom_range(0, 1), $urandom()});
		case ($urandom_range(0, 5))
			0:       return x;
			1:       return ONE_Q32;
			default: return ONE_Q32 - CFG_DATA_W'($urandom_range(0, 1 << 24));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_chunk();
		logic [CFG_DATA_W-1:0] x;
		x = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'({$urandom_range(0, 1), $urandom()})
			: '0;
		case ($urandom_range(0, 7))
			0:       x[CHUNK_W-1:0] = '0;
			1:       x[CHUNK_W-1:0] = CHUNK_W'(MAX_CHUNK);
			2:       x[CHUNK_W-1:0] = CHUNK_W'($urandom_range(MAX_CHUNK + 1, 127));
			default: x[CHUNK_W-1:0] = CHUNK_W'($urandom_range(1, 8));
		endcase
		return x;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_start();
		logic [CFG_DATA_W-1:0] x;
		x = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'({$urandom_range(0, 1), $urandom()})
			: '0;
		case ($urandom_range(0, 9))
			0:       x[START_W-1:0] = '0;
			1:       x[START_W-1:0] = START_MAX;
			2:       x[START_W-1:0] = START_W'($urandom_range(60, 150));
			default: x[START_W-1:0] = START_W'($urandom_range(1, 40));
		endcase
		return x;
	endfunction

	function automatic int row_remaining();
		return (row_pos >= row_index) ? 1 : int'(row_index) - int'(row_pos) + 1;
	endfunction

	task automatic test_reset_defaults();
		send_node(VALUE_MAX);
		send_node(VALUE_MAX);
		send_node('0);
		send_node(VALUE_MAX);
		send_node(VALUE_MAX);
		send_node('0);
	endtask

	task automatic test_zero_band();
		configure(HALF_Q32, ONE_Q32, CFG_DATA_W'(0), CFG_DATA_W'(1));
		send_node(rand_node());
		send_node(VALUE_MAX);
		send_node(rand_node());
		configure(HALF_Q32, ONE_Q32, CFG_DATA_W'(5), CFG_DATA_W'(0));
		send_node(rand_node());
		send_node('0);
	endtask

	task automatic test_factor_limits();
		configure(DATA_MAX, DATA_MAX, CFG_DATA_W'(7'h7F), CFG_DATA_W'(3));
		repeat (4) send_node(rand_node());
		configure('0, '0, CFG_DATA_W'(2), CFG_DATA_W'(2));
		repeat (3) send_node(rand_node());
		configure(ONE_Q32, ONE_Q32 - 1'b1, CFG_DATA_W'(3), CFG_DATA_W'(3));
		send_node(VALUE_MAX);
		repeat (3) send_node(rand_node());
	endtask

	task automatic test_midrow_change();
		configure(rand_prob(), rand_discount(), CFG_DATA_W'(3), CFG_DATA_W'(6));
		repeat (4) send_node(rand_node());
		configure(up_prob, disc, CFG_DATA_W'(2), CFG_DATA_W'(2));
		send_node(rand_node());
	endtask

	task automatic test_random_rows();
		int first;
		int budget;
		// fill every wavefront cell so any later band may read it
		configure(rand_prob(), rand_discount(), CFG_DATA_W'(MAX_CHUNK),
			CFG_DATA_W'(MAX_CHUNK));
		first = nodes_sent;
		repeat (row_remaining()) send_node(rand_node());
		while (nodes_sent < first + RANDOM_NODES) begin
			configure(rand_prob(), rand_discount(), rand_chunk(), rand_start());
			burst = ($urandom_range(0, 3) == 0);
			budget = $urandom_range(20, 90);
			while (budget > 0) begin
				send_node(rand_node());
				budget--;
				if ($urandom_range(0, 199) == 0)
					hold_until_drained();
			end
			if ($urandom_range(0, 3) != 0 && row_remaining() <= 300)
				repeat (row_remaining()) send_node(rand_node());
			burst = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		if (sink_free) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
		end else if (out_stall) begin
			out_stall <= 1'b0;
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
				: $urandom_range(0, 12);
		end else if ($urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
				: $urandom_range(0, 2);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (expected_nodes.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", result_value));
			end else begin
				want = expected_nodes.pop_front();
				if (result_value !== want.value)
					report_mismatch($sformatf("result_value %h, want %h",
						result_value, want.value));
				if (last_of_row !== want.last)
					report_mismatch($sformatf("last_of_row %b, want %b",
						last_of_row, want.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		node_value <= '0;
		out_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_UP_PROB;
		cfg_data <= '0;
		up_prob = HALF_Q32;
		disc = ONE_Q32;
		chunk = CHUNK_W'(1);
		row_index = START_W'(1);
		row_pos = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_zero_band();
		test_factor_limits();
		test_midrow_change();
		test_random_rows();
		settle();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/brtc_pkg.sv
rtl/brtc_cell.sv
rtl/binomial_tree_row_collapse_top.sv
tb/tb.sv
